// ----- design/qcd_pkg.sv -----
// Shared types, constants and sine table builder for the QAM correlator demodulator.
package qcd_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned CARRIER_BITS = 16;
  localparam int unsigned PROD_BITS    = SAMPLE_BITS + CARRIER_BITS;
  localparam int unsigned SUM_BITS     = 44;
  localparam int unsigned FRAC_SHIFT   = 24;
  localparam int unsigned LEN_BITS     = 12;
  localparam int unsigned PHASE_BITS   = 32;
  localparam int unsigned MODE_BITS    = 2;
  localparam int unsigned SINE_ADDR_BITS_DEF = 10;

  // Modulation codes
  localparam logic [MODE_BITS-1:0] MODE_QPSK  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_QAM16 = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_QAM64 = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_LEN   = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [MODE_BITS-1:0]  MODE_RST = MODE_QPSK;
  localparam logic [LEN_BITS-1:0]   LEN_RST  = 12'd1000;
  localparam logic [PHASE_BITS-1:0] STEP_RST = 32'd429496730;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic                          frame_start;
  } qcd_in_t;

  typedef struct packed {
    logic [5:0] symbol_bits;
    logic [2:0] bit_count;
  } qcd_out_t;

  // Build one sine table entry: quarter-wave polynomial, mirrored and signed.
  function automatic logic signed [CARRIER_BITS-1:0] sine_entry(int unsigned a,
                                                                int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    int unsigned quad;
    int unsigned off;
    logic signed [CARRIER_BITS-1:0] mag;
    quad = (a >> (abits - 2)) & 3;
    off  = a & ((1 << (abits - 2)) - 1);
    x    = 64'(off) << (18 - abits);
    if ((quad & 1) != 0) begin
      x = 64'd65536 - x;
    end
    x2 = (x * x) >> 16;
    t  = (64'd307 * x2) >> 16;
    t  = 64'd5223 - t;
    t  = (t * x2) >> 16;
    t  = 64'd42334 - t;
    t  = (t * x2) >> 16;
    t  = 64'd102944 - t;
    y  = (x * t) >> 16;
    y  = (y + 64'd2) >> 2;
    if (y > 64'd16384) begin
      y = 64'd16384;
    end
    mag = CARRIER_BITS'(y);
    return ((quad & 2) != 0) ? -mag : mag;
  endfunction

endpackage

// ----- design/qcd_carrier.sv -----
// Carrier phase accumulator and sine/cosine table with registered reads.
module qcd_carrier import qcd_pkg::*; #(
  parameter int unsigned SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           load_i,
  input  logic                           frame_start_i,
  input  logic [PHASE_BITS-1:0]          phase_step_i,
  output logic signed [CARRIER_BITS-1:0] sin_o,
  output logic signed [CARRIER_BITS-1:0] cos_o
);

  localparam int unsigned Depth   = 1 << SINE_ADDR_BITS;
  localparam logic [SINE_ADDR_BITS-1:0] Quarter = SINE_ADDR_BITS'(Depth / 4);

  logic signed [CARRIER_BITS-1:0] rom [Depth];
  logic [PHASE_BITS-1:0]          phase_q, phase_d, phase_use;
  logic [SINE_ADDR_BITS-1:0]      sin_addr, cos_addr;
  logic signed [CARRIER_BITS-1:0] sin_q, cos_q;

  // Fill the table with constants
  for (genvar g = 0; g < Depth; g++) begin : g_rom
    assign rom[g] = sine_entry(g, SINE_ADDR_BITS);
  end

  // Restart the phase at frame start, then step it per sample
  assign phase_use = frame_start_i ? '0 : phase_q;
  assign phase_d   = phase_use + phase_step_i;
  assign sin_addr  = phase_use[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign cos_addr  = sin_addr + Quarter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (load_i) begin
      phase_q <= phase_d;
    end
  end

  // Read both carrier values; hold while the pipe stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= rom[sin_addr];
      cos_q <= rom[cos_addr];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- design/qcd_slicer.sv -----
// Level slicer: maps the I and Q symbol sums to natural-binary bits.
module qcd_slicer import qcd_pkg::*; (
  input  logic signed [SUM_BITS-1:0] sum_i_i,
  input  logic signed [SUM_BITS-1:0] sum_q_i,
  input  logic [MODE_BITS-1:0]       mode_i,
  input  logic [LEN_BITS-1:0]        len_i,
  output qcd_out_t                   result_o
);

  logic signed [SUM_BITS-1:0] t1, t2, t3;
  logic [6:0] thr_i, thr_q;
  logic [2:0] idx_i, idx_q;

  // Thresholds k * N * 2^24 for k = 1, 2, 3
  assign t1 = signed'({{(SUM_BITS - LEN_BITS - FRAC_SHIFT){1'b0}}, len_i, {FRAC_SHIFT{1'b0}}});
  assign t2 = t1 <<< 1;
  assign t3 = t1 + t2;

  // Compare against every level boundary, k from -3 up to 3
  assign thr_i = {sum_i_i >= t3, sum_i_i >= t2, sum_i_i >= t1, sum_i_i >= 0,
                  sum_i_i >= -t1, sum_i_i >= -t2, sum_i_i >= -t3};
  assign thr_q = {sum_q_i >= t3, sum_q_i >= t2, sum_q_i >= t1, sum_q_i >= 0,
                  sum_q_i >= -t1, sum_q_i >= -t2, sum_q_i >= -t3};

  always_comb begin
    idx_i    = '0;
    idx_q    = '0;
    result_o = '0;
    case (mode_i)
      MODE_QAM16: begin
        idx_i = 3'($countones(thr_i[4:2]));
        idx_q = 3'($countones(thr_q[4:2]));
        result_o.symbol_bits = {2'b00, idx_i[1:0], idx_q[1:0]};
        result_o.bit_count   = 3'd4;
      end
      MODE_QAM64: begin
        idx_i = 3'($countones(thr_i));
        idx_q = 3'($countones(thr_q));
        result_o.symbol_bits = {idx_i, idx_q};
        result_o.bit_count   = 3'd6;
      end
      default: begin
        // QPSK, and the unused code decodes the same way
        idx_i = {2'b00, thr_i[3]};
        idx_q = {2'b00, thr_q[3]};
        result_o.symbol_bits = {4'b0000, idx_i[0], idx_q[0]};
        result_o.bit_count   = 3'd2;
      end
    endcase
  end

endmodule

// ----- design/qam_correlator_demodulator.sv -----
// Top level of the coherent QAM correlator demodulator.
//
// Input channel: one complex sample per beat (in_valid_i / in_ready_o); frame_start
// restarts the carrier phase, the sample count and both sums before that sample.
// Output channel: one symbol decision per beat (out_valid_o / out_ready_i), issued
// on the last sample of each symbol, with 2, 4 or 6 valid bits.
// Config channel: index 0 mode, 1 symbol length, 2 phase step; always ready. The user
// must see it is written only while no samples are in flight; the block does not enforce it.
// Throughput: one sample per cycle while the pipe is not stalled. The decision for the
// beat that carries the symbol's last sample passes through registered steps: table
// read, multiply, accumulate, then slice into the output register.
// Stall: while a finished symbol sits behind an output beat the receiver has not taken,
// the whole pipe holds and in_ready_o falls; otherwise samples keep flowing.
// Reset: phase, count, sums and all valid flags clear; mode is QPSK, symbol
// length 1000, phase step 429496730.
module qam_correlator_demodulator import qcd_pkg::*; #(
  parameter int unsigned SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  qcd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output qcd_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [PHASE_BITS-1:0] cfg_data_i
);

  // Configuration
  logic [MODE_BITS-1:0]  mode_q;
  logic [LEN_BITS-1:0]   len_q, len_eff;
  logic [PHASE_BITS-1:0] step_q;

  // Control
  logic adv, accept, stall;
  logic [LEN_BITS-1:0] cnt_q, cnt_d, cnt_use, cnt_inc;
  logic last;

  // Stage 1: samples beside the table read
  logic s1_valid_q, s1_clr_q, s1_last_q;
  logic signed [SAMPLE_BITS-1:0]  s1_si_q, s1_sq_q;
  logic signed [CARRIER_BITS-1:0] sin_w, cos_w;

  // Stage 2: products
  logic s2_valid_q, s2_clr_q, s2_last_q;
  logic signed [PROD_BITS-1:0] s2_pi_q, s2_pq_q;

  // Stage 3: finished sums
  logic signed [SUM_BITS-1:0] acc_i_q, acc_q_q, base_i, base_q, nxt_i, nxt_q;
  logic s3_valid_q;
  logic signed [SUM_BITS-1:0] s3_sum_i_q, s3_sum_q_q;

  // Output register
  qcd_out_t slice_w;
  qcd_out_t out_q;
  logic     out_valid_q;

  // Write the configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RST;
      len_q  <= LEN_RST;
      step_q <= STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE: mode_q <= cfg_data_i[MODE_BITS-1:0];
        REG_LEN:  len_q  <= cfg_data_i[LEN_BITS-1:0];
        REG_STEP: step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign len_eff = (len_q == '0) ? LEN_BITS'(1) : len_q;

  // Hold the whole pipe only when a finished symbol cannot enter the output register
  assign stall      = s3_valid_q && out_valid_q && !out_ready_i;
  assign adv        = !stall;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // Count samples and flag the symbol's last one
  assign cnt_use = in_data_i.frame_start ? '0 : cnt_q;
  assign cnt_inc = cnt_use + LEN_BITS'(1);
  assign last    = (cnt_inc == '0) || (cnt_inc >= len_eff);
  assign cnt_d   = last ? '0 : cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  qcd_carrier #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_carrier (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .load_i       (accept),
    .frame_start_i(in_data_i.frame_start),
    .phase_step_i (step_q),
    .sin_o        (sin_w),
    .cos_o        (cos_w)
  );

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_si_q   <= in_data_i.sample_i;
      s1_sq_q   <= in_data_i.sample_q;
      s1_clr_q  <= in_data_i.frame_start;
      s1_last_q <= last;
    end
  end

  // Stage 2: mix down, real by cosine and imaginary by sine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pi_q   <= s1_si_q * cos_w;
      s2_pq_q   <= s1_sq_q * sin_w;
      s2_clr_q  <= s1_clr_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: accumulate, drop the sums at frame start and after each symbol
  assign base_i = s2_clr_q ? '0 : acc_i_q;
  assign base_q = s2_clr_q ? '0 : acc_q_q;
  assign nxt_i  = base_i + SUM_BITS'(s2_pi_q);
  assign nxt_q  = base_q + SUM_BITS'(s2_pq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_i_q    <= '0;
      acc_q_q    <= '0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q && s2_last_q;
      if (s2_valid_q) begin
        acc_i_q <= s2_last_q ? '0 : nxt_i;
        acc_q_q <= s2_last_q ? '0 : nxt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_sum_i_q <= nxt_i;
      s3_sum_q_q <= nxt_q;
    end
  end

  qcd_slicer u_slicer (
    .sum_i_i (s3_sum_i_q),
    .sum_q_i (s3_sum_q_q),
    .mode_i  (mode_q),
    .len_i   (len_eff),
    .result_o(slice_w)
  );

  // Output register: load a decision, clear once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s3_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q) begin
      out_q <= slice_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Input stops only behind a blocked output beat
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && s3_valid_q))
    else $error("input stalled without a blocked decision");

  // A blocked decision keeps its sums
  a_hold_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (s3_valid_q && $stable(s3_sum_i_q) && $stable(s3_sum_q_q)))
    else $error("stalled symbol sums changed");

  // Bit count is one of the three legal widths
  a_bit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.bit_count == 3'd2 || out_data_o.bit_count == 3'd4 ||
                     out_data_o.bit_count == 3'd6))
    else $error("illegal bit count");

  // Unused high bits stay clear for QPSK decisions
  a_bits_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bit_count == 3'd2) |-> (out_data_o.symbol_bits[5:2] == 4'd0))
    else $error("QPSK decision has stray high bits");

endmodule

// ----- test/qam_correlator_demodulator_tb.sv -----
// Self-checking testbench for the QAM correlator demodulator: random traffic, own predictor.
`timescale 1ns / 1ps

module qam_correlator_demodulator_tb;
  import qcd_pkg::*;

  typedef longint unsigned u64_t;

  localparam int ROM_ABITS      = SINE_ADDR_BITS_DEF;
  localparam int ITEM_TARGET    = 1400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // Mode code outside the defined set; decodes as QPSK
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  qcd_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  qcd_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = REG_MODE;
  logic [PHASE_BITS-1:0] cfg_data_i = '0;

  // Samples waiting to be driven and decisions waiting to come out
  qcd_in_t  samples_to_send[$];
  qcd_out_t expected_symbols[$];

  // Predictor state, advanced on accepted beats
  logic [MODE_BITS-1:0]         p_mode;
  logic [LEN_BITS-1:0]          p_len;
  logic [PHASE_BITS-1:0]        p_step;
  logic [PHASE_BITS-1:0]        p_phase;
  logic [LEN_BITS-1:0]          p_count;
  logic signed [SUM_BITS-1:0]   p_sum_i;
  logic signed [SUM_BITS-1:0]   p_sum_q;

  // Generator view of the carrier, used to shape samples toward target levels
  logic [PHASE_BITS-1:0] gen_phase = '0;
  logic [PHASE_BITS-1:0] gen_step  = STEP_RST;
  logic [LEN_BITS-1:0]   gen_len   = LEN_RST;
  int                    items_queued = 0;

  logic [MODE_BITS-1:0] mode_pool [4] = '{MODE_QPSK, MODE_QAM16, MODE_QAM64, MODE_SPARE};

  int unsigned in_gap;
  int unsigned out_stall;
  bit          in_calm;
  bit          out_calm;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  qam_correlator_demodulator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Carrier value in Q1.14 for a phase word; cosine reads a quarter turn ahead
  function automatic int carrier_lookup(logic [PHASE_BITS-1:0] phase_word, bit cosine);
    logic [ROM_ABITS-1:0] addr;
    u64_t u;
    u64_t u2;
    u64_t acc;
    addr = phase_word[PHASE_BITS-1 -: ROM_ABITS];
    if (cosine) begin
      addr = addr + (ROM_ABITS'(1) << (ROM_ABITS - 2));
    end
    u = u64_t'(addr[ROM_ABITS-3:0]) << (18 - ROM_ABITS);
    // Odd quadrants run the quarter wave backwards
    if (addr[ROM_ABITS-2]) begin
      u = 65536 - u;
    end
    u2  = (u * u) >> 16;
    acc = 5223 - ((307 * u2) >> 16);
    acc = 42334 - ((acc * u2) >> 16);
    acc = 102944 - ((acc * u2) >> 16);
    acc = (((u * acc) >> 16) + 2) >> 2;
    if (acc > 16384) begin
      acc = 16384;
    end
    return addr[ROM_ABITS-1] ? -int'(acc) : int'(acc);
  endfunction

  // Count the thresholds k * scale, k in [kmin, kmax], that the sum reaches
  function automatic logic [2:0] level_of(logic signed [SUM_BITS-1:0] acc, longint scale,
                                          int kmin, int kmax);
    logic [2:0] idx;
    idx = '0;
    for (int k = kmin; k <= kmax; k++) begin
      if (longint'(acc) >= k * scale) begin
        idx++;
      end
    end
    return idx;
  endfunction

  // Mostly short gaps, a few long ones, none in a calm stretch
  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Target average in sixteenths, centered on one constellation level with jitter
  function automatic int random_target(int levels);
    int lvl;
    lvl = $urandom_range(0, levels - 1);
    return (2 * lvl - (levels - 1)) * 8 + int'($urandom_range(0, 20)) - 10;
  endfunction

  task automatic queue_raw(logic [SAMPLE_BITS-1:0] si, logic [SAMPLE_BITS-1:0] sq, bit fs);
    qcd_in_t item;
    if (fs) begin
      gen_phase = '0;
    end
    item.sample_i    = si;
    item.sample_q    = sq;
    item.frame_start = fs;
    samples_to_send.insert(samples_to_send.size(), item);
    items_queued++;
    gen_phase = gen_phase + gen_step;
  endtask

  // Scale each sample by its own carrier so the correlation average lands near the target
  task automatic queue_shaped(int ti, int tq, bit fs);
    logic [PHASE_BITS-1:0] ph;
    int vi;
    int vq;
    int noise;
    ph    = fs ? '0 : gen_phase;
    noise = int'($urandom_range(0, 64)) - 32;
    vi    = ti * carrier_lookup(ph, 1'b1) / 128 + noise;
    noise = int'($urandom_range(0, 64)) - 32;
    vq    = tq * carrier_lookup(ph, 1'b0) / 128 + noise;
    vi    = (vi > 32767) ? 32767 : ((vi < -32768) ? -32768 : vi);
    vq    = (vq > 32767) ? 32767 : ((vq < -32768) ? -32768 : vq);
    queue_raw(SAMPLE_BITS'(vi), SAMPLE_BITS'(vq), fs);
  endtask

  task automatic queue_symbol(int levels, bit fs);
    int sym_len;
    int ti;
    int tq;
    sym_len = (gen_len == '0) ? 1 : int'(gen_len);
    ti = random_target(levels);
    tq = random_target(levels);
    for (int k = 0; k < sym_len; k++) begin
      queue_shaped(ti, tq, fs && k == 0);
    end
  endtask

  // Leaves valid high so that back-to-back writes need no extra drop
  task automatic write_reg(logic [1:0] idx, logic [PHASE_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == REG_LEN) begin
      gen_len = val[LEN_BITS-1:0];
    end
    if (idx == REG_STEP) begin
      gen_step = val;
    end
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apply_setting(logic [MODE_BITS-1:0] m, logic [LEN_BITS-1:0] len,
                               logic [PHASE_BITS-1:0] step);
    write_reg(REG_MODE, PHASE_BITS'(m));
    write_reg(REG_LEN, PHASE_BITS'(len));
    write_reg(REG_STEP, step);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the sender until every queued sample is in and every decision is out;
  // poll on the falling edge so the driver and monitor updates have landed
  task automatic settle();
    while (samples_to_send.size() != 0 || in_valid_i || expected_symbols.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sample driver and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
      in_calm    <= 1'b0;
      p_mode     = MODE_RST;
      p_len      = LEN_RST;
      p_step     = STEP_RST;
      p_phase    = '0;
      p_count    = '0;
      p_sum_i    = '0;
      p_sum_q    = '0;
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MODE: p_mode = cfg_data_i[MODE_BITS-1:0];
          REG_LEN:  p_len  = cfg_data_i[LEN_BITS-1:0];
          REG_STEP: p_step = cfg_data_i;
          default: ;
        endcase
      end

      // Accumulate the accepted sample and close the symbol when the count is reached
      if (in_valid_i && in_ready_o) begin : predict
        int unsigned n;
        int unsigned nb;
        longint scale;
        logic [2:0] li;
        logic [2:0] lq;
        qcd_out_t dec;
        n = (p_len == '0) ? 1 : int'(p_len);
        if (in_data_i.frame_start) begin
          p_phase = '0;
          p_count = '0;
          p_sum_i = '0;
          p_sum_q = '0;
        end
        p_sum_i = p_sum_i + SUM_BITS'(longint'($signed(in_data_i.sample_i))
                                      * carrier_lookup(p_phase, 1'b1));
        p_sum_q = p_sum_q + SUM_BITS'(longint'($signed(in_data_i.sample_q))
                                      * carrier_lookup(p_phase, 1'b0));
        p_phase = p_phase + p_step;
        p_count = p_count + 1'b1;
        if (p_count == '0 || p_count >= n) begin
          scale = longint'(n) << FRAC_SHIFT;
          case (p_mode)
            MODE_QAM16: begin
              nb = 2;
              li = level_of(p_sum_i, scale, -1, 1);
              lq = level_of(p_sum_q, scale, -1, 1);
            end
            MODE_QAM64: begin
              nb = 3;
              li = level_of(p_sum_i, scale, -3, 3);
              lq = level_of(p_sum_q, scale, -3, 3);
            end
            default: begin
              nb = 1;
              li = level_of(p_sum_i, scale, 0, 0);
              lq = level_of(p_sum_q, scale, 0, 0);
            end
          endcase
          dec.symbol_bits = 6'((int'(li) << nb) | int'(lq));
          dec.bit_count   = 3'(2 * nb);
          expected_symbols.insert(expected_symbols.size(), dec);
          p_count = '0;
          p_sum_i = '0;
          p_sum_q = '0;
        end
      end

      // Advance to the next beat once the current one is gone, after its gap
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          in_data_i  <= samples_to_send.pop_front();
          in_valid_i <= 1'b1;
          in_gap     <= idle_len(in_calm);
          if ($urandom_range(0, 63) == 0) begin
            in_calm <= !in_calm;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Decision monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
      out_calm    <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_symbols.size() == 0) begin
          $error("decision beat with no symbol pending: symbol_bits %0d bit_count %0d",
                 out_data_o.symbol_bits, out_data_o.bit_count);
          mismatches++;
        end else begin : compare
          qcd_out_t want;
          want = expected_symbols.pop_front();
          if (out_data_o.symbol_bits !== want.symbol_bits) begin
            $error("symbol_bits: expected %0d, got %0d", want.symbol_bits,
                   out_data_o.symbol_bits);
            mismatches++;
          end
          if (out_data_o.bit_count !== want.bit_count) begin
            $error("bit_count: expected %0d, got %0d", want.bit_count, out_data_o.bit_count);
            mismatches++;
          end
        end
      end
      if (out_stall != 0) begin
        out_stall   <= out_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 30) begin
          out_stall <= idle_len(out_calm);
        end
        if ($urandom_range(0, 127) == 0) begin
          out_calm <= !out_calm;
        end
      end
    end
  end

  // Drop the run if no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_no;
    int nsym;
    int sym_len;
    int levels;
    int cut;
    int ti;
    int tq;
    int v;
    int unsigned r;
    logic [MODE_BITS-1:0]  m;
    logic [LEN_BITS-1:0]   len;
    logic [PHASE_BITS-1:0] step;
    bit realign;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short symbols with the reset mode and phase step
    write_reg(REG_LEN, PHASE_BITS'(3));
    cfg_valid_i <= 1'b0;
    queue_symbol(2, 1'b1);
    queue_symbol(2, 1'b0);
    settle();

    // One-sample symbols on a quarter-turn carrier: samples on and just past each level boundary
    apply_setting(MODE_QAM64, LEN_BITS'(1), 32'h4000_0000);
    for (int j = 0; j < 14; j++) begin
      v = (j / 2 - 3) * 1024;
      if (j % 2 == 1) begin
        v = v + ((j / 2 - 3 > 0) ? 1 : -1);
      end
      queue_raw(SAMPLE_BITS'(v), SAMPLE_BITS'(-v), j % 4 == 0);
    end
    // Full-scale samples
    queue_raw(16'h7FFF, 16'h8000, 1'b1);
    queue_raw(16'h8000, 16'h7FFF, 1'b0);
    queue_raw(16'h7FFF, 16'h7FFF, 1'b0);
    queue_raw(16'h8000, 16'h8000, 1'b0);
    settle();

    // Lower the length below the running count: the next sample ends the symbol
    write_reg(REG_MODE, PHASE_BITS'(MODE_QAM16));
    write_reg(REG_LEN, PHASE_BITS'(4095));
    cfg_valid_i <= 1'b0;
    ti = random_target(4);
    tq = random_target(4);
    for (int k = 0; k < 20; k++) begin
      queue_shaped(ti, tq, k == 0);
    end
    settle();
    write_reg(REG_LEN, PHASE_BITS'(5));
    cfg_valid_i <= 1'b0;
    queue_shaped(ti, tq, 1'b0);
    queue_symbol(4, 1'b0);
    queue_symbol(4, 1'b0);
    settle();

    // Lower the length to exactly the count reached on the next sample
    write_reg(REG_LEN, PHASE_BITS'(4095));
    cfg_valid_i <= 1'b0;
    for (int k = 0; k < 7; k++) begin
      queue_shaped(ti, tq, k == 0);
    end
    settle();
    write_reg(REG_LEN, PHASE_BITS'(8));
    cfg_valid_i <= 1'b0;
    queue_shaped(ti, tq, 1'b0);
    queue_symbol(4, 1'b0);
    settle();

    // Random settings, each followed by a run of framed symbols with some noise
    phase_no = 0;
    while (items_queued < ITEM_TARGET) begin
      if (phase_no == 0) begin
        m    = MODE_SPARE;
        len  = '0;
        step = '1;
      end else if (phase_no == 1) begin
        m    = MODE_QAM64;
        len  = LEN_BITS'(1);
        step = '0;
      end else begin
        m = mode_pool[$urandom_range(0, 3)];
        r = $urandom_range(0, 99);
        if (r < 5) begin
          len = '0;
        end else if (r < 60) begin
          len = LEN_BITS'($urandom_range(1, 4));
        end else if (r < 90) begin
          len = LEN_BITS'($urandom_range(5, 12));
        end else begin
          len = LEN_BITS'($urandom_range(13, 48));
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
          step = '0;
        end else if (r < 20) begin
          step = '1;
        end else if (r < 30) begin
          step = PHASE_BITS'($urandom_range(1, 1 << 20));
        end else begin
          step = $urandom();
        end
      end
      apply_setting(m, len, step);
      case (m)
        MODE_QAM16: levels = 4;
        MODE_QAM64: levels = 8;
        default:    levels = 2;
      endcase
      sym_len = (gen_len == '0) ? 1 : int'(gen_len);
      realign = 1'b1;
      nsym = $urandom_range(2, 10);
      for (int s = 0; s < nsym; s++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // Raw noise, occasionally with a stray frame start
          repeat ($urandom_range(1, 6)) begin
            queue_raw(SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()),
                      $urandom_range(0, 9) == 0);
          end
          realign = 1'b1;
        end else if (r < 16 && sym_len > 1) begin
          // Cut a symbol short and restart the frame on the next one
          cut = $urandom_range(1, sym_len - 1);
          ti = random_target(levels);
          tq = random_target(levels);
          for (int k = 0; k < cut; k++) begin
            queue_shaped(ti, tq, realign && k == 0);
          end
          realign = 1'b1;
        end else begin
          queue_symbol(levels, realign);
          realign = 1'b0;
        end
      end
      settle();
      phase_no++;
    end

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
